// File: src/rfcs_pkg.sv
// Shared types and constants for the run fill / copy segmenter.
package rfcs_pkg;

    localparam int unsigned ADDRESS_SPACE_DEFAULT   = 65536;
    localparam int unsigned PROTECTED_LIMIT_DEFAULT = 544;

    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned THR_W    = 8;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 64;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd27;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ADDRESS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIXED_PORT_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_THRESHOLD   = 2'd2;

    localparam int unsigned MAX_SEGS  = 4;
    localparam int unsigned SEG_CNT_W = 3;
    localparam int unsigned SLOT_W    = 2;

    localparam logic KIND_COPY = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] offset;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] value;
        logic              last;
    } seg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_address;
        logic              fixed_port_mode;
        logic [THR_W-1:0]  run_threshold;
        logic [ADDR_W-1:0] start_wrapped;   // start_address modulo the address space
    } cfg_t;

    typedef struct packed {
        logic [SEG_CNT_W-1:0]         count;
        seg_t [MAX_SEGS-1:0]          slot;
    } seg_bundle_t;

endpackage

// File: src/rfcs_seg_engine.sv
// Run tracking state and the combinational segment decision for one byte.
module rfcs_seg_engine #(
    parameter int unsigned ADDRESS_SPACE   = rfcs_pkg::ADDRESS_SPACE_DEFAULT,
    parameter int unsigned PROTECTED_LIMIT = rfcs_pkg::PROTECTED_LIMIT_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rfcs_pkg::cfg_t             cfg,
    input  logic [rfcs_pkg::BYTE_W-1:0] item_byte,
    input  logic                       item_last,
    input  logic                       advance,
    output rfcs_pkg::seg_bundle_t      bundle
);

    localparam logic [rfcs_pkg::POS_W-1:0] AS_L = rfcs_pkg::POS_W'(ADDRESS_SPACE);
    localparam int unsigned PCW = (PROTECTED_LIMIT > 0) ? $clog2(PROTECTED_LIMIT + 1) : 1;
    localparam int unsigned LIM_W = 11;
    localparam logic [LIM_W-1:0] PL_L = LIM_W'(PROTECTED_LIMIT);
    localparam int unsigned NCAND = 6;

    logic [rfcs_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [rfcs_pkg::POS_W-1:0]  seg_start_reg, seg_start_next;
    logic [rfcs_pkg::POS_W-1:0]  run_start_reg, run_start_next;
    logic [rfcs_pkg::LEN_W-1:0]  run_len_reg, run_len_next;
    logic [rfcs_pkg::BYTE_W-1:0] run_value_reg, run_value_next;
    logic [PCW-1:0]              prot_cnt_reg, prot_cnt_next;

    logic [rfcs_pkg::THR_W-1:0]  thr_eff;
    logic [LIM_W-1:0]            limit;
    logic                        in_prot;
    logic [rfcs_pkg::POS_W-1:0]  pos1;
    logic                        finish;
    logic [rfcs_pkg::POS_W-1:0]  seg2, seg3, rs2;
    logic [rfcs_pkg::LEN_W-1:0]  rl2;
    logic [rfcs_pkg::BYTE_W-1:0] rv2;
    logic [PCW-1:0]              pc2;
    rfcs_pkg::seg_t              cand [NCAND];
    logic [NCAND-1:0]            cand_v;
    logic [rfcs_pkg::SEG_CNT_W-1:0] cnt;

    function automatic rfcs_pkg::seg_t make_seg(
        input logic                        kind,
        input logic [rfcs_pkg::POS_W-1:0]  off,
        input logic [rfcs_pkg::LEN_W-1:0]  len,
        input logic [rfcs_pkg::BYTE_W-1:0] val,
        input rfcs_pkg::cfg_t              c
    );
        rfcs_pkg::seg_t              s;
        logic [rfcs_pkg::POS_W-1:0]  sum;
        sum = {1'b0, c.start_wrapped} + off;
        if (sum >= AS_L) begin
            sum = sum - AS_L;
        end
        s.kind    = kind;
        s.address = c.fixed_port_mode ? c.start_address : sum[rfcs_pkg::ADDR_W-1:0];
        s.offset  = off[rfcs_pkg::ADDR_W-1:0];
        s.length  = len;
        s.value   = val;
        s.last    = 1'b0;
        return s;
    endfunction

    always_comb begin
        thr_eff = (cfg.run_threshold == '0) ? rfcs_pkg::THR_W'(1) : cfg.run_threshold;
        limit   = '0;
        if (!cfg.fixed_port_mode && (cfg.start_address < rfcs_pkg::ADDR_W'(PL_L))) begin
            limit = PL_L - cfg.start_address[LIM_W-1:0];
        end
        in_prot = pos_reg < rfcs_pkg::POS_W'(limit);

        for (int i = 0; i < NCAND; i++) begin
            cand[i] = '0;
        end
        cand_v = '0;

        seg2 = seg_start_reg;
        rs2  = run_start_reg;
        rl2  = run_len_reg;
        rv2  = run_value_reg;
        pc2  = prot_cnt_reg;

        if (in_prot) begin
            pc2 = prot_cnt_reg + PCW'(1);
        end else if (run_len_reg == '0) begin
            seg2 = pos_reg;
            rs2  = pos_reg;
            rv2  = item_byte;
            rl2  = rfcs_pkg::LEN_W'(1);
        end else if (item_byte == run_value_reg) begin
            rl2 = run_len_reg + rfcs_pkg::LEN_W'(1);
        end else begin
            // A different byte ends the current run; settle it if long enough.
            if (run_len_reg >= rfcs_pkg::LEN_W'(thr_eff)) begin
                cand_v[0] = run_start_reg > seg_start_reg;
                cand[0]   = make_seg(rfcs_pkg::KIND_COPY, seg_start_reg,
                                     run_start_reg - seg_start_reg, '0, cfg);
                cand_v[1] = 1'b1;
                cand[1]   = make_seg(rfcs_pkg::KIND_FILL, run_start_reg, run_len_reg,
                                     run_value_reg, cfg);
                seg2      = run_start_reg + run_len_reg;
            end
            rs2 = pos_reg;
            rv2 = item_byte;
            rl2 = rfcs_pkg::LEN_W'(1);
        end

        pos1   = pos_reg + rfcs_pkg::POS_W'(1);
        finish = item_last || (pos1 >= AS_L);
        seg3   = seg2;

        if (finish && (rl2 != '0)) begin
            if (rl2 >= rfcs_pkg::LEN_W'(thr_eff)) begin
                cand_v[2] = rs2 > seg2;
                cand[2]   = make_seg(rfcs_pkg::KIND_COPY, seg2, rs2 - seg2, '0, cfg);
                cand_v[3] = 1'b1;
                cand[3]   = make_seg(rfcs_pkg::KIND_FILL, rs2, rl2, rv2, cfg);
                seg3      = rs2 + rl2;
            end
            cand_v[4] = pos1 > seg3;
            cand[4]   = make_seg(rfcs_pkg::KIND_COPY, seg3, pos1 - seg3, '0, cfg);
        end
        if (finish && (pc2 != '0)) begin
            // Held-back protected bytes go out as one copy, after everything else.
            cand_v[5] = 1'b1;
            cand[5]   = make_seg(rfcs_pkg::KIND_COPY, '0, rfcs_pkg::LEN_W'(pc2), '0, cfg);
        end

        bundle = '0;
        cnt    = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cand_v[i]) begin
                if (cnt < rfcs_pkg::SEG_CNT_W'(rfcs_pkg::MAX_SEGS)) begin
                    bundle.slot[cnt[rfcs_pkg::SLOT_W-1:0]] = cand[i];
                end
                cnt = cnt + rfcs_pkg::SEG_CNT_W'(1);
            end
        end
        if (finish && (cnt != '0)) begin
            bundle.slot[rfcs_pkg::SLOT_W'(cnt - rfcs_pkg::SEG_CNT_W'(1))].last = 1'b1;
        end
        bundle.count = cnt;

        if (finish) begin
            pos_next       = '0;
            seg_start_next = '0;
            run_start_next = '0;
            run_len_next   = '0;
            run_value_next = '0;
            prot_cnt_next  = '0;
        end else begin
            pos_next       = pos1;
            seg_start_next = seg2;
            run_start_next = rs2;
            run_len_next   = rl2;
            run_value_next = rv2;
            prot_cnt_next  = pc2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            seg_start_reg <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            run_value_reg <= '0;
            prot_cnt_reg  <= '0;
        end else if (advance) begin
            pos_reg       <= pos_next;
            seg_start_reg <= seg_start_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            run_value_reg <= run_value_next;
            prot_cnt_reg  <= prot_cnt_next;
        end
    end

    // The segment start never runs ahead of the byte position within a transfer.
    a_seg_not_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_start_reg <= pos_reg)
        else $error("segment start beyond byte position");

    // An open run always lies inside the bytes seen so far.
    a_run_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_len_reg != '0) |-> (run_start_reg + run_len_reg == pos_reg))
        else $error("open run does not end at byte position");

endmodule

// File: src/rfcs_out_buf.sv
// Holds the segments settled by one byte and hands them out one beat at a time.
module rfcs_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  rfcs_pkg::seg_bundle_t bundle_in,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output rfcs_pkg::seg_t        head,
    output logic                  buf_free
);

    rfcs_pkg::seg_t [rfcs_pkg::MAX_SEGS-1:0] slot_reg;
    logic [rfcs_pkg::SEG_CNT_W-1:0]           count_reg;
    logic [rfcs_pkg::SLOT_W-1:0]              rd_reg;
    logic                                     valid_reg;
    logic                                     pop;
    logic                                     drain_last;

    assign pop        = valid_reg && m_tready;
    assign drain_last = pop &&
        (rd_reg == rfcs_pkg::SLOT_W'(count_reg - rfcs_pkg::SEG_CNT_W'(1)));
    assign buf_free   = !valid_reg || drain_last;
    assign m_tvalid   = valid_reg;
    assign head       = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            rd_reg    <= '0;
            count_reg <= bundle_in.count;
        end else if (pop) begin
            if (drain_last) begin
                valid_reg <= 1'b0;
            end else begin
                rd_reg <= rd_reg + rfcs_pkg::SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= bundle_in.slot;
        end
    end

    // A new group of segments only lands once the previous one is fully drained.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> buf_free)
        else $error("segment group overwritten before drained");

    // A held group always has between one and four segments.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (count_reg != '0) &&
                      (count_reg <= rfcs_pkg::SEG_CNT_W'(rfcs_pkg::MAX_SEGS)))
        else $error("held segment count out of range");

endmodule

// File: src/run_fill_copy_segmenter_core.sv
// Top level of the run fill / copy segmenter: configuration, input register and output.
//
// The block takes the bytes of one write transfer, one beat per byte with tlast on the
// final byte, and emits segment descriptors: a run of one byte value at least
// run_threshold long becomes a fill segment, the bytes between such runs become copy
// segments, and in memory mode the bytes addressed below the protected limit are held
// back and reported as one copy segment at the very end of the transfer. A segment is
// emitted once it is settled, so the descriptors for a run appear when the run is
// broken by a different byte or by the end of the transfer; m_tlast marks the final
// descriptor of a transfer. One byte can be accepted in every clock cycle. A byte that
// settles k segments (at most four) holds the output side for k beats, because a
// four-entry holding buffer delivers one descriptor per beat. Bytes that settle nothing
// pass meanwhile, but the next byte that settles any segments waits in the input
// register until the last held descriptor leaves, so it stalls the input while the held
// descriptors drain; while m_tready is low the stall lasts as long as the receiver holds
// off. The first descriptor of a byte passes the input register, then the holding buffer.
// Memory addresses wrap modulo the address space; the start address is reduced once,
// when it is written, through a 256-entry constant table. Configuration is written over
// the plain write port and must only change while no transfer is in flight. No clearing
// pass is needed after reset.
module run_fill_copy_segmenter_core #(
    parameter int unsigned ADDRESS_SPACE   = rfcs_pkg::ADDRESS_SPACE_DEFAULT,
    parameter int unsigned PROTECTED_LIMIT = rfcs_pkg::PROTECTED_LIMIT_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [rfcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Byte stream in.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rfcs_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    // Segment descriptors out.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] seg_address, [31:16] seg_offset, [48:32] seg_length,
    // [56:49] fill_value, [63:57] zero
    output logic [rfcs_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tuser,   // seg_kind
    output logic                            m_tlast    // seg_last
);

    localparam logic [rfcs_pkg::POS_W-1:0] AS_L = rfcs_pkg::POS_W'(ADDRESS_SPACE);
    localparam int unsigned HI_ENTRIES = 256;

    // Configuration registers.
    rfcs_pkg::cfg_t cfg_reg;

    // Start address reduction: (hi * 256) mod ADDRESS_SPACE from a constant table,
    // plus the low byte, then one conditional subtract.
    logic [rfcs_pkg::ADDR_W-1:0] hi_mod [HI_ENTRIES];
    logic [rfcs_pkg::POS_W-1:0]  wrap_sum;
    logic [rfcs_pkg::ADDR_W-1:0] wrap_next;

    for (genvar g = 0; g < HI_ENTRIES; g++) begin : g_hi_mod
        localparam int unsigned HM = (g * 256) % ADDRESS_SPACE;
        assign hi_mod[g] = HM[rfcs_pkg::ADDR_W-1:0];
    end

    always_comb begin
        wrap_sum  = {1'b0, hi_mod[cfg_wdata[15:8]]} + rfcs_pkg::POS_W'(cfg_wdata[7:0]);
        wrap_next = (wrap_sum >= AS_L) ? rfcs_pkg::ADDR_W'(wrap_sum - AS_L)
                                       : wrap_sum[rfcs_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_address   <= '0;
            cfg_reg.fixed_port_mode <= 1'b0;
            cfg_reg.run_threshold   <= rfcs_pkg::THRESHOLD_RESET;
            cfg_reg.start_wrapped   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rfcs_pkg::REG_START_ADDRESS: begin
                    cfg_reg.start_address <= cfg_wdata;
                    cfg_reg.start_wrapped <= wrap_next;
                end
                rfcs_pkg::REG_FIXED_PORT_MODE: begin
                    cfg_reg.fixed_port_mode <= cfg_wdata[0];
                end
                rfcs_pkg::REG_RUN_THRESHOLD: begin
                    cfg_reg.run_threshold <= cfg_wdata[rfcs_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register. The byte held here is worked on in the cycle after its beat and
    // moves on (advance) unless its segments would overwrite ones still waiting.
    logic                         in_valid_reg;
    logic [rfcs_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                         in_last_reg;
    logic                         advance;
    logic                         buf_free;
    rfcs_pkg::seg_bundle_t        bundle;
    rfcs_pkg::seg_t               head;

    assign advance  = in_valid_reg && ((bundle.count == '0) || buf_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[rfcs_pkg::BYTE_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    rfcs_seg_engine #(
        .ADDRESS_SPACE   (ADDRESS_SPACE),
        .PROTECTED_LIMIT (PROTECTED_LIMIT)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .item_byte (in_byte_reg),
        .item_last (in_last_reg),
        .advance   (advance),
        .bundle    (bundle)
    );

    rfcs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && (bundle.count != '0)),
        .bundle_in (bundle),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .head      (head),
        .buf_free  (buf_free)
    );

    assign m_tdata = {7'd0, head.value, head.length, head.offset, head.address};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // One byte never settles more segments than the holding buffer has entries.
    a_bundle_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> (bundle.count <= rfcs_pkg::SEG_CNT_W'(rfcs_pkg::MAX_SEGS)))
        else $error("byte settles more segments than the buffer holds");

    // A byte that is held back keeps its place in the input register.
    a_hold_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held byte lost from input register");

endmodule
